// ===== rtl/olir_pkg.sv =====
package olir_pkg;

    // Storage size
    localparam int CAPACITY      = 1024;
    localparam int ELEMENT_WIDTH = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // Beat field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 1;
    localparam int ELEM_W   = 32;
    localparam int COUNT_W  = 11;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_POP    = 2'd2,
        OP_REMOVE = 2'd3
    } olir_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RM_HEAD,
        ST_RM_SHIFT
    } olir_state_t;

    typedef struct packed {
        olir_op_t             op;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   value;
    } olir_cmd_t;

    function automatic logic [ELEMENT_WIDTH-1:0] to_elem(input logic [VALUE_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[ELEMENT_WIDTH-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] to_field(input logic [ELEMENT_WIDTH-1:0] e);
        logic [63:0] w;
        w = 64'(e);
        return w[ELEM_W-1:0];
    endfunction

endpackage

// ===== rtl/olir_req_if.sv =====
interface olir_req_if;
    logic                          valid;
    logic                          ready;
    logic [olir_pkg::ACTION_W-1:0] action;
    logic [olir_pkg::INDEX_W-1:0]  index;
    logic [olir_pkg::VALUE_W-1:0]  value;

    modport source (output valid, action, index, value, input ready);
    modport sink   (input valid, action, index, value, output ready);
endinterface

// ===== rtl/olir_rsp_if.sv =====
interface olir_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [olir_pkg::STATUS_W-1:0] status;
    logic [olir_pkg::ELEM_W-1:0]   element;
    logic [olir_pkg::COUNT_W-1:0]  count;

    modport source (output valid, status, element, count, input ready);
    modport sink   (input valid, status, element, count, output ready);
endinterface

// ===== rtl/olir_ram.sv =====
module olir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/olir_front.sv =====
module olir_front (
    input  logic                clk,
    input  logic                rst_n,
    olir_req_if.sink            req,
    output logic                cmd_valid,
    output olir_pkg::olir_cmd_t cmd,
    input  logic                cmd_take
);
    import olir_pkg::*;

    olir_cmd_t           fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0]  fill_reg, fill_next;
    logic                push;
    olir_cmd_t           in_cmd;

    assign req.ready = (fill_reg < QFILL_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;

    // decode the beat into a command
    always_comb
    begin
        in_cmd.op    = olir_op_t'(req.action);
        in_cmd.index = req.index;
        in_cmd.value = req.value;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_take)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, cmd_take})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign cmd_valid = (fill_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];
endmodule

// ===== rtl/olir_back.sv =====
module olir_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  olir_pkg::olir_cmd_t cmd,
    output logic                cmd_take,
    olir_rsp_if.source          rsp
);
    import olir_pkg::*;

    olir_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         ptr_reg, ptr_next;
    logic [ADDR_W-1:0]         last_reg, last_next;
    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [ELEM_W-1:0]         out_elem_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    logic                      out_load;
    logic [STATUS_W-1:0]       load_status;
    logic [ELEM_W-1:0]         load_elem;
    logic [COUNT_W-1:0]        load_count;

    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ELEMENT_WIDTH-1:0]  mem_wdata;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [ELEMENT_WIDTH-1:0]  mem_rdata;
    logic                      idx_ok;

    olir_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idx_ok = (32'(cmd.index) < 32'(count_reg));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        cmd_take    = 1'b0;
        out_load    = 1'b0;
        load_status = STATUS_OK;
        load_elem   = '0;
        load_count  = COUNT_W'(count_reg);
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(count_reg);
        mem_wdata   = to_elem(cmd.value);
        mem_raddr   = ADDR_W'(cmd.index);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_take = 1'b1;
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            out_load = 1'b1;
                            if (32'(count_reg) >= CAPACITY)
                            begin
                                load_status = STATUS_ERR;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                load_count = COUNT_W'(count_next);
                            end
                        end
                        OP_READ:
                        begin
                            if (!idx_ok)
                            begin
                                out_load    = 1'b1;
                                load_status = STATUS_ERR;
                            end
                            else
                            begin
                                state_next = ST_RD_WAIT;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load    = 1'b1;
                                load_status = STATUS_ERR;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                mem_raddr  = ADDR_W'(count_next);
                                state_next = ST_RD_WAIT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!idx_ok)
                            begin
                                out_load    = 1'b1;
                                load_status = STATUS_ERR;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                ptr_next   = ADDR_W'(cmd.index);
                                last_next  = ADDR_W'(count_next);
                                state_next = ST_RM_HEAD;
                            end
                        end
                        default:
                        begin
                            out_load    = 1'b1;
                            load_status = STATUS_ERR;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                out_load   = 1'b1;
                load_elem  = to_field(mem_rdata);
                state_next = ST_IDLE;
            end
            ST_RM_HEAD:
            begin
                // removed element is out; the tail moves down one place at a time
                out_load  = 1'b1;
                load_elem = to_field(mem_rdata);
                mem_raddr = ptr_reg + 1'b1;
                if (ptr_reg < last_reg)
                begin
                    state_next = ST_RM_SHIFT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RM_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                mem_raddr = ptr_reg + 2'd2;
                ptr_next  = ptr_reg + 1'b1;
                if ((ptr_reg + 1'b1) >= last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        last_reg <= last_next;
        if (out_load)
        begin
            out_status_reg <= load_status;
            out_elem_reg   <= load_elem;
            out_count_reg  <= load_count;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.element = out_elem_reg;
    assign rsp.count   = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("element count above capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg)
        else $error("result register overwritten while pending");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RM_SHIFT) |-> (ptr_reg < last_reg))
        else $error("shift pointer past last element");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> (state_reg == ST_IDLE && cmd_valid))
        else $error("command taken while busy");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_WAIT) |=> out_valid_reg)
        else $error("read did not produce a result");
endmodule

// ===== rtl/ordered_list_with_indexed_remove.sv =====
// channel  role  fields                  beat moves
// req      sink  action, index, value    one request
// rsp      src   status, element, count  one result per request
//
// Append and every error load the result straight from the idle state;
// read and pop first wait on the registered read of the single store RAM.
// Remove returns the element from ST_RM_HEAD; the tail moves one element
// per cycle through the RAM's read and write ports, and no new request
// starts meanwhile. A two-beat command queue keeps req open while rsp stalls.
// Reset clears the count and control only; the store needs no clearing.
module ordered_list_with_indexed_remove (
    input  logic       clk,
    input  logic       rst_n,
    olir_req_if.sink   req,
    olir_rsp_if.source rsp
);
    import olir_pkg::*;

    logic      cmd_valid;
    olir_cmd_t cmd;
    logic      cmd_take;

    olir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    olir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .rsp       (rsp)
    );
endmodule

// ===== tb/ordered_list_with_indexed_remove_test.sv =====
module ordered_list_with_indexed_remove_test;
    import olir_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   element;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    typedef struct packed {
        olir_op_t            op;
        logic [INDEX_W-1:0]  index;
        logic [VALUE_W-1:0]  value;
        bit                  typed;
        list_result_t        res;
    } script_row_t;

    localparam int SCRIPT_LEN        = 20;
    localparam int LOW_RANDOM_ITEMS  = 540;
    localparam int HIGH_RANDOM_ITEMS = 80;
    localparam int LONG_HOLD         = 400;
    localparam int HOLD_AFTER_BEATS  = 300;
    localparam int IDLE_LIMIT        = 10000;
    localparam int TAIL_CYCLES       = 40;

    localparam list_result_t NO_RES = '0;

    // expected result is typed in only where it is obvious; other rows use the predictor
    script_row_t directed_script [SCRIPT_LEN] = '{
        '{OP_POP,    10'd0,    32'h0000_0000, 1'b1, '{STATUS_ERR, 32'h0, 11'd0}},
        '{OP_READ,   10'd0,    32'hFFFF_FFFF, 1'b1, '{STATUS_ERR, 32'h0, 11'd0}},
        '{OP_REMOVE, 10'd1023, 32'h0000_0000, 1'b1, '{STATUS_ERR, 32'h0, 11'd0}},
        '{OP_APPEND, 10'd0,    32'hFFFF_FFFF, 1'b1, '{STATUS_OK,  32'h0, 11'd1}},
        '{OP_APPEND, 10'd0,    32'h0000_0000, 1'b1, '{STATUS_OK,  32'h0, 11'd2}},
        '{OP_APPEND, 10'd1023, 32'hA5A5_A5A5, 1'b1, '{STATUS_OK,  32'h0, 11'd3}},
        '{OP_READ,   10'd0,    32'h0000_0000, 1'b1, '{STATUS_OK,  32'hFFFF_FFFF, 11'd3}},
        '{OP_READ,   10'd3,    32'h0000_0000, 1'b1, '{STATUS_ERR, 32'h0, 11'd3}},
        '{OP_READ,   10'd1023, 32'h0000_0000, 1'b1, '{STATUS_ERR, 32'h0, 11'd3}},
        '{OP_REMOVE, 10'd3,    32'h0000_0000, 1'b1, '{STATUS_ERR, 32'h0, 11'd3}},
        '{OP_REMOVE, 10'd1,    32'h0000_0000, 1'b1, '{STATUS_OK,  32'h0, 11'd2}},
        '{OP_READ,   10'd1,    32'h0000_0000, 1'b0, NO_RES},
        '{OP_APPEND, 10'd0,    32'h5A5A_5A5A, 1'b0, NO_RES},
        '{OP_REMOVE, 10'd2,    32'h0000_0000, 1'b0, NO_RES},
        '{OP_POP,    10'd1023, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{OP_REMOVE, 10'd0,    32'h0000_0000, 1'b0, NO_RES},
        '{OP_POP,    10'd0,    32'h0000_0000, 1'b1, '{STATUS_ERR, 32'h0, 11'd0}},
        '{OP_APPEND, 10'd1023, 32'h0000_0001, 1'b1, '{STATUS_OK,  32'h0, 11'd1}},
        '{OP_READ,   10'd0,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{OP_POP,    10'd0,    32'h0000_0000, 1'b1, '{STATUS_OK,  32'h1, 11'd0}}
    };

    logic clk;
    logic rst_n;

    olir_req_if req();
    olir_rsp_if rsp();

    ordered_list_with_indexed_remove i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [ELEMENT_WIDTH-1:0] stored_elems [$];
    list_result_t             pending_results [$];

    int mismatch_count = 0;
    int req_beats      = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    bit long_hold_done = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic list_result_t predict_request(input olir_op_t op,
                                                     input logic [INDEX_W-1:0] idx,
                                                     input logic [VALUE_W-1:0] val);
        list_result_t r;
        int           n;
        r = '0;
        r.status = STATUS_OK;
        n = stored_elems.size();
        case (op)
            OP_APPEND:
                if (n >= CAPACITY)
                    r.status = STATUS_ERR;
                else
                    stored_elems.push_back(val[ELEMENT_WIDTH-1:0]);
            OP_READ:
                if (int'(idx) >= n)
                    r.status = STATUS_ERR;
                else
                    r.element = ELEM_W'(stored_elems[idx]);
            OP_POP:
                if (n == 0)
                    r.status = STATUS_ERR;
                else
                    r.element = ELEM_W'(stored_elems.pop_back());
            OP_REMOVE:
                if (int'(idx) >= n)
                    r.status = STATUS_ERR;
                else
                begin
                    r.element = ELEM_W'(stored_elems[idx]);
                    stored_elems.delete(idx);
                end
            default:
                r.status = STATUS_ERR;
        endcase
        r.count = COUNT_W'(stored_elems.size());
        return r;
    endfunction

    // drive one request beat; predict at the accepting edge so the list stays in step
    task automatic put_request(input olir_op_t op, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] val, input bit typed,
                               input list_result_t res);
        int           gap;
        list_result_t predicted;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                req.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        req.valid  = 1'b1;
        req.action = op;
        req.index  = idx;
        req.value  = val;
        do
            @(posedge clk);
        while (!req.ready);
        predicted = predict_request(op, idx, val);
        pending_results.push_back(typed ? res : predicted);
        req_beats++;
        burst_left--;
    endtask

    task automatic random_request();
        int                 n;
        int                 roll;
        int                 append_w;
        olir_op_t           op;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        n = stored_elems.size();
        // steer the count toward a middle band
        append_w = (n < 24) ? 45 : ((n > 72) ? 15 : 30);
        roll = $urandom_range(0, 99);
        if (roll < append_w)
            op = OP_APPEND;
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_READ;
                1:       op = OP_POP;
                default: op = OP_REMOVE;
            endcase
        end
        roll = $urandom_range(0, 19);
        if (n > 0 && roll < 15)
            idx = INDEX_W'($urandom_range(0, n - 1));
        else if (roll < 17)
            idx = INDEX_W'(n);
        else
            idx = INDEX_W'($urandom);
        roll = $urandom_range(0, 9);
        if (roll == 0)
            val = '0;
        else if (roll == 1)
            val = '1;
        else
            val = VALUE_W'($urandom);
        put_request(op, idx, val, 1'b0, NO_RES);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver: one long hold-off, otherwise stall patterns that change over time
    initial
    begin
        int hold;
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && req_beats >= HOLD_AFTER_BEATS)
            begin
                rsp.ready = 1'b0;
                for (hold = 0; hold < LONG_HOLD; hold++)
                    @(negedge clk);
                long_hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (mode)
                0:       rsp.ready = 1'b1;
                1:       rsp.ready = ($urandom_range(0, 3) != 0);
                default: rsp.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with none expected: status %0d element %h count %0d",
                         $time, rsp.status, rsp.element, rsp.count);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.element !== want.element)
                begin
                    $display("%0t: element expected %h actual %h",
                             $time, want.element, rsp.element);
                    mismatch_count++;
                end
                if (rsp.count !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, rsp.count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int k;
        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.action = OP_APPEND;
        req.index  = '0;
        req.value  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < SCRIPT_LEN; k++)
            put_request(directed_script[k].op, directed_script[k].index,
                        directed_script[k].value, directed_script[k].typed,
                        directed_script[k].res);
        wait_drained();

        for (k = 0; k < LOW_RANDOM_ITEMS; k++)
            random_request();
        wait_drained();

        // fill to capacity, then the full-store cases and a remove that shifts everything
        while (stored_elems.size() < CAPACITY)
            put_request(OP_APPEND, INDEX_W'($urandom), VALUE_W'($urandom), 1'b0, NO_RES);
        put_request(OP_APPEND, '1, '1, 1'b1, '{STATUS_ERR, '0, COUNT_W'(CAPACITY)});
        put_request(OP_READ, INDEX_W'(CAPACITY - 1), '0, 1'b0, NO_RES);
        put_request(OP_REMOVE, '0, '0, 1'b0, NO_RES);
        put_request(OP_REMOVE, INDEX_W'(CAPACITY - 1), '0, 1'b1,
                    '{STATUS_ERR, '0, COUNT_W'(CAPACITY - 1)});
        put_request(OP_APPEND, '0, 32'h8000_0001, 1'b1, '{STATUS_OK, '0, COUNT_W'(CAPACITY)});
        put_request(OP_READ, INDEX_W'(CAPACITY - 1), '0, 1'b0, NO_RES);
        wait_drained();

        for (k = 0; k < HIGH_RANDOM_ITEMS; k++)
            random_request();
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
